### rtl/srec_pkg.sv
// Shared types, codes and helpers for the S-record S2 parser.
// No dependencies; imported by srec_cfg, srec_parse and the core module.
package srec_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NOT_S     = 2'd0;
  localparam logic [1:0] ERR_NON_HEX   = 2'd1;
  localparam logic [1:0] ERR_DESCEND   = 2'd2;
  localparam logic [1:0] ERR_SHORT_CNT = 2'd3;

  // Input actions.
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Characters of interest.
  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_2  = 8'h32;

  // Column bookkeeping.
  localparam int         COL_W     = 9;
  localparam logic [8:0] COL_MAX   = 9'd511;
  localparam logic [8:0] COL_DATA  = 9'd10;
  localparam logic [8:0] COL_ADDR9 = 9'd9;
  localparam logic [7:0] CNT_HDR   = 8'd4;

  // Register map.
  localparam int PADDR_W = 3;
  localparam logic REG_ADDR_MASK = 1'b0;
  localparam logic [31:0] ADDR_MASK_RESET = 32'h000F_FFFF;

  // Decoded hex digit: bad flag and nibble.
  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  // Returns the nibble of an ASCII hex digit, or the bad flag.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad   = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

### rtl/srec_cfg.sv
// APB-style configuration register holding the address mask.
// Depends on srec_pkg for the register map and reset value.
module srec_cfg import srec_pkg::*; #(
  parameter int ADDR_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [ADDR_WIDTH-1:0] address_mask
);

  logic reg_sel;

  assign reg_sel = (paddr[2] == REG_ADDR_MASK);
  assign pready  = 1'b1;

  // The mask is written on the access cycle of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      address_mask <= ADDR_MASK_RESET[ADDR_WIDTH-1:0];
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      address_mask <= pwdata[ADDR_WIDTH-1:0];
    end
  end

  // Read data; unused addresses read as zero.
  always_comb begin
    prdata = 32'd0;
    if (reg_sel) begin
      prdata[ADDR_WIDTH-1:0] = address_mask;
    end
  end

endmodule

### rtl/srec_parse.sv
// Per-character parser state and next-state logic for S2 records.
// Depends on srec_pkg for codes and the hex decoder.
module srec_parse import srec_pkg::*; #(
  parameter int ADDR_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  action,
  input  logic [7:0]            char_code,
  input  logic [ADDR_WIDTH-1:0] address_mask,
  output logic                  res_valid,
  output logic [1:0]            res_kind,
  output logic [7:0]            res_data,
  output logic [ADDR_WIDTH-1:0] res_fill,
  output logic [1:0]            res_error,
  output logic [ADDR_WIDTH:0]   res_offset
);

  localparam logic [ADDR_WIDTH:0] OFS_MAX = '1;

  logic [COL_W-1:0]      col, col_next;
  logic                  is_data, is_data_next;
  logic [7:0]            rec_count, rec_count_next;
  logic [ADDR_WIDTH-1:0] addr_acc, addr_acc_next;
  logic [ADDR_WIDTH:0]   wofs, wofs_next;
  logic [3:0]            hi_nib, hi_nib_next;
  logic [7:0]            data_left, data_left_next;
  logic                  halted, halted_next;

  hex_t                  hx;
  logic                  incomplete;
  logic [ADDR_WIDTH-1:0] acc_new;
  logic [ADDR_WIDTH-1:0] masked;

  assign hx         = hex_decode(char_code);
  assign incomplete = is_data && (col < COL_DATA || data_left != 8'd0);
  assign acc_new    = {addr_acc[ADDR_WIDTH-5:0], hx.value};
  assign masked     = acc_new & address_mask;

  // Next state and result for one accepted item.
  always_comb begin
    col_next       = col;
    is_data_next   = is_data;
    rec_count_next = rec_count;
    addr_acc_next  = addr_acc;
    wofs_next      = wofs;
    hi_nib_next    = hi_nib;
    data_left_next = data_left;
    halted_next    = halted;
    res_valid      = 1'b0;
    res_kind       = KIND_DATA;
    res_data       = 8'd0;
    res_fill       = '0;
    res_error      = ERR_NOT_S;
    res_offset     = wofs;

    if (accept && !halted) begin
      if (action == ACT_END) begin
        halted_next = 1'b1;
        res_valid   = 1'b1;
        if (incomplete) begin
          res_kind  = KIND_ERROR;
          res_error = ERR_NON_HEX;
        end else begin
          res_kind  = KIND_DONE;
        end
      end else if (char_code == CHAR_NL) begin
        if (col == '0) begin
          halted_next = 1'b1;
          res_valid   = 1'b1;
          res_kind    = KIND_ERROR;
          res_error   = ERR_NOT_S;
        end else if (incomplete) begin
          halted_next = 1'b1;
          res_valid   = 1'b1;
          res_kind    = KIND_ERROR;
          res_error   = ERR_NON_HEX;
        end else begin
          col_next       = '0;
          is_data_next   = 1'b0;
          data_left_next = 8'd0;
        end
      end else begin
        col_next = (col < COL_MAX) ? col + 9'd1 : COL_MAX;
        if (col == 9'd0) begin
          if (char_code != CHAR_S) begin
            halted_next = 1'b1;
            res_valid   = 1'b1;
            res_kind    = KIND_ERROR;
            res_error   = ERR_NOT_S;
          end
        end else if (col == 9'd1) begin
          is_data_next   = (char_code == CHAR_2);
          data_left_next = 8'd0;
        end else if (!is_data) begin
          // Other record types are skipped to the newline.
        end else if (col >= COL_DATA && data_left == 8'd0) begin
          // Checksum and trailing characters are ignored.
        end else if (hx.bad) begin
          halted_next = 1'b1;
          res_valid   = 1'b1;
          res_kind    = KIND_ERROR;
          res_error   = ERR_NON_HEX;
        end else if (col == 9'd2) begin
          hi_nib_next = hx.value;
        end else if (col == 9'd3) begin
          rec_count_next = {hi_nib, hx.value};
        end else if (col <= COL_ADDR9) begin
          addr_acc_next = acc_new;
          if (col == COL_ADDR9) begin
            // Address complete: order check, count check, then fill.
            if ({1'b0, masked} < wofs) begin
              halted_next = 1'b1;
              res_valid   = 1'b1;
              res_kind    = KIND_ERROR;
              res_error   = ERR_DESCEND;
            end else if (rec_count < CNT_HDR) begin
              halted_next = 1'b1;
              res_valid   = 1'b1;
              res_kind    = KIND_ERROR;
              res_error   = ERR_SHORT_CNT;
            end else begin
              data_left_next = rec_count - CNT_HDR;
              if ({1'b0, masked} > wofs) begin
                wofs_next = {1'b0, masked};
                res_valid = 1'b1;
                res_kind  = KIND_FILL;
                res_fill  = masked - wofs[ADDR_WIDTH-1:0];
              end
            end
          end
        end else if (!col[0]) begin
          hi_nib_next = hx.value;
        end else begin
          // Second digit of a pair: issue the data byte.
          res_valid      = 1'b1;
          res_kind       = KIND_DATA;
          res_data       = {hi_nib, hx.value};
          data_left_next = data_left - 8'd1;
          if (wofs < OFS_MAX) begin
            wofs_next = wofs + 1'b1;
          end
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      is_data   <= 1'b0;
      rec_count <= 8'd0;
      addr_acc  <= '0;
      wofs      <= '0;
      hi_nib    <= 4'd0;
      data_left <= 8'd0;
      halted    <= 1'b0;
    end else begin
      col       <= col_next;
      is_data   <= is_data_next;
      rec_count <= rec_count_next;
      addr_acc  <= addr_acc_next;
      wofs      <= wofs_next;
      hi_nib    <= hi_nib_next;
      data_left <= data_left_next;
      halted    <= halted_next;
    end
  end

endmodule

### rtl/srec_skid.sv
// Output register with a skid stage, so input and output handshakes are decoupled.
// No package dependencies.
module srec_skid #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;

  // The upstream side is held off only while the skid stage is occupied.
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

### rtl/srec_s2_to_binary_parser_core.sv
// S-record S2 parser: one character per transfer in, data bytes and fills out.
// Results are registered in the output buffer, via the skid stage while out_stall holds.
// Throughput: one character per cycle while the skid stage is empty (in_stall low).
// Reset (rst, synchronous): parser state cleared, mask to 0xFFFFF, outputs empty.
// Depends on srec_pkg, srec_cfg, srec_parse and srec_skid.
module srec_s2_to_binary_parser_core import srec_pkg::*; #(
  parameter int ADDR_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  action,
  input  logic [7:0]            char_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [7:0]            data_value,
  output logic [ADDR_WIDTH-1:0] fill_count,
  output logic [1:0]            error_code,
  output logic [ADDR_WIDTH:0]   offset,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int RES_W = 2 + 8 + ADDR_WIDTH + 2 + ADDR_WIDTH + 1;

  logic                  accept;
  logic [ADDR_WIDTH-1:0] address_mask;
  logic                  res_valid;
  logic [1:0]            res_kind;
  logic [7:0]            res_data;
  logic [ADDR_WIDTH-1:0] res_fill;
  logic [1:0]            res_error;
  logic [ADDR_WIDTH:0]   res_offset;
  logic [RES_W-1:0]      res_packed;
  logic [RES_W-1:0]      out_packed;
  logic                  skid_full;

  assign in_stall = skid_full;
  assign accept   = in_valid && !skid_full;

  srec_cfg #(.ADDR_WIDTH(ADDR_WIDTH)) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .address_mask (address_mask)
  );

  srec_parse #(.ADDR_WIDTH(ADDR_WIDTH)) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .action       (action),
    .char_code    (char_code),
    .address_mask (address_mask),
    .res_valid    (res_valid),
    .res_kind     (res_kind),
    .res_data     (res_data),
    .res_fill     (res_fill),
    .res_error    (res_error),
    .res_offset   (res_offset)
  );

  // Result fields travel through the output buffer as one word.
  assign res_packed = {res_kind, res_data, res_fill, res_error, res_offset};

  srec_skid #(.WIDTH(RES_W)) u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_packed),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_packed)
  );

  assign {kind, data_value, fill_count, error_code, offset} = out_packed;

endmodule
